// ===== hdl/fca_pkg.sv =====
// ---------------------------------------------------------------------------
// fca_pkg
// shared types, codes and constants of the chain allocator
// ---------------------------------------------------------------------------
package fca_pkg;

   localparam int unsigned TYPE_W  = 3;
   localparam int unsigned LINK_W  = 16;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned CSR_W   = 2;

   localparam logic [TYPE_W-1:0] REQ_LOAD   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_RESIZE = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_FREE   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_NTH    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_COUNT  = 3'd4;

   localparam logic [CSR_W-1:0] CSR_USABLE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FREE   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_END    = 2'd2;

   localparam logic ST_OK       = 1'b0;
   localparam logic ST_NO_SPACE = 1'b1;

   localparam logic [COUNT_W-1:0] RESET_USABLE = 11'd1024;
   localparam logic [LINK_W-1:0]  RESET_FREE   = 16'hFFFF;
   localparam logic [LINK_W-1:0]  RESET_END    = 16'hFFFE;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_RESIZE,
      OP_FREE,
      OP_NTH,
      OP_COUNT,
      OP_NOP
   } fca_op_type;

   typedef struct packed {
      fca_op_type          op;
      logic [LINK_W-1:0]   chain_head;
      logic [COUNT_W-1:0]  new_count;
      logic [COUNT_W-1:0]  old_count;
      logic [INDEX_W-1:0]  entry_index;
      logic [LINK_W-1:0]   entry_value;
   } fca_cmd_type;

   typedef struct packed {
      logic        valid;
      fca_cmd_type cmd;
   } fca_front_stat_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } fca_back_stat_type;

   typedef struct packed {
      logic [COUNT_W-1:0] usable_entries;
      logic [LINK_W-1:0]  free_marker;
      logic [LINK_W-1:0]  end_marker;
   } fca_cfg_type;

   function automatic fca_op_type fca_classify(input logic [TYPE_W-1:0] t);
      fca_op_type op;
      case (t)
         REQ_LOAD:   op = OP_LOAD;
         REQ_RESIZE: op = OP_RESIZE;
         REQ_FREE:   op = OP_FREE;
         REQ_NTH:    op = OP_NTH;
         REQ_COUNT:  op = OP_COUNT;
         default:    op = OP_NOP;
      endcase
      return op;
   endfunction

endpackage

// ===== hdl/fca_if.sv =====
// ---------------------------------------------------------------------------
// fca_if
// request, response and register write channels
// ---------------------------------------------------------------------------
interface fca_req_if;
   import fca_pkg::*;
   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  req_type;
   logic [LINK_W-1:0]  chain_head;
   logic [COUNT_W-1:0] new_count;
   logic [COUNT_W-1:0] old_count;
   logic [INDEX_W-1:0] entry_index;
   logic [LINK_W-1:0]  entry_value;
   modport source (output valid, req_type, chain_head, new_count, old_count,
                   entry_index, entry_value, input ready);
   modport sink (input valid, req_type, chain_head, new_count, old_count,
                 entry_index, entry_value, output ready);
endinterface

interface fca_rsp_if;
   import fca_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [LINK_W-1:0] result_value;
   modport source (output valid, status, result_value, input ready);
   modport sink (input valid, status, result_value, output ready);
endinterface

interface fca_csr_if;
   import fca_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_W-1:0]  wr_index;
   logic [LINK_W-1:0] wr_data;
   modport source (output valid, wr_index, wr_data, input ready);
   modport sink (input valid, wr_index, wr_data, output ready);
endinterface

// ===== hdl/fat_chain_allocator_core.sv =====
// ---------------------------------------------------------------------------
// fat_chain_allocator_core
// file allocation table of next-sector links with entry load, chain resize, free,
// nth-step lookup and free count
//
// channels: req_ch takes one request a beat (valid/ready); rsp_ch returns
// exactly one result beat per request, in order; csr_ch writes the usable
// entry count, free marker and end marker, always ready; the user writes
// it only while idle, which the block itself does not enforce.
// a load or unknown type goes straight to its result; free and nth walk
// the chain link by link; count reads each usable entry up to the table
// size; resize walks the existing links, scans for free entries, frees
// surplus links and, when space runs out, puts back the entries it linked.
// table reads go through the registered read port of the link table memory.
// a two-deep request queue lets requests be taken while the engine works;
// a result register holds the last result while the receiver stalls, and
// the engine waits on it before finishing the next request.
// reset: the table is swept to the reset free marker, one entry a cycle,
// with req_ch held not ready; csr_ch stays open.
// ---------------------------------------------------------------------------
module fat_chain_allocator_core #(
   parameter int unsigned TABLE_ENTRIES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   fca_req_if.sink    req_ch,
   fca_rsp_if.source  rsp_ch,
   fca_csr_if.sink    csr_ch
);
   import fca_pkg::*;

   fca_cfg_type        cfg;
   logic [COUNT_W-1:0] usable_ff;
   logic [LINK_W-1:0]  free_ff;
   logic [LINK_W-1:0]  end_ff;
   fca_front_stat_type front_stat;
   fca_back_stat_type  back_stat;
   logic               csr_wr;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= RESET_USABLE;
         free_ff   <= RESET_FREE;
         end_ff    <= RESET_END;
      end else if (csr_wr) begin
         case (csr_ch.wr_index)
            CSR_USABLE: usable_ff <= csr_ch.wr_data[COUNT_W-1:0];
            CSR_FREE:   free_ff   <= csr_ch.wr_data;
            CSR_END:    end_ff    <= csr_ch.wr_data;
            default: ;
         endcase
      end
   end

   assign cfg.usable_entries = usable_ff;
   assign cfg.free_marker    = free_ff;
   assign cfg.end_marker     = end_ff;

   fca_front u_front (
      .clock(clock), .reset(reset), .req(req_ch),
      .back_stat(back_stat), .front_stat(front_stat)
   );

   fca_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg),
      .front_stat(front_stat), .back_stat(back_stat), .rsp(rsp_ch)
   );
endmodule

// ===== hdl/fca_ram.sv =====
// ---------------------------------------------------------------------------
// fca_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
module fca_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/fca_front.sv =====
// ---------------------------------------------------------------------------
// fca_front
// accepts requests, classifies the type and queues them for the engine
// ---------------------------------------------------------------------------
module fca_front (
   input  logic                       clock,
   input  logic                       reset,
   fca_req_if.sink                    req,
   input  fca_pkg::fca_back_stat_type back_stat,
   output fca_pkg::fca_front_stat_type front_stat
);
   import fca_pkg::*;

   fca_cmd_type q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push, pop;
   fca_cmd_type cmd;

   assign req.ready = (fill_ff != 2'd2) && back_stat.init_done;
   assign push      = req.valid && req.ready;
   assign pop       = back_stat.pop && (fill_ff != 2'd0);

   always_comb begin
      cmd.op          = fca_classify(req.req_type);
      cmd.chain_head  = req.chain_head;
      cmd.new_count   = req.new_count;
      cmd.old_count   = req.old_count;
      cmd.entry_index = req.entry_index;
      cmd.entry_value = req.entry_value;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign front_stat.valid = (fill_ff != 2'd0);
   assign front_stat.cmd   = q_ff[rd_ptr_ff];
endmodule

// ===== hdl/fca_engine.sv =====
// ---------------------------------------------------------------------------
// fca_engine
// executes queued requests on the link table, owns the result register
// ---------------------------------------------------------------------------
module fca_engine #(
   parameter int unsigned TABLE_ENTRIES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fca_pkg::fca_cfg_type        cfg,
   input  fca_pkg::fca_front_stat_type front_stat,
   output fca_pkg::fca_back_stat_type  back_stat,
   fca_rsp_if.source                   rsp
);
   import fca_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned LW = AW + 1;
   localparam int unsigned LOG_W = AW + LINK_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_FR, S_FR_W, S_NT, S_NT_W, S_CN, S_CN_W,
      S_RS_STEP, S_RS_RD, S_RS_CHK, S_RS_SCAN, S_RS_SCW, S_RS_END,
      S_RS_SUR, S_RS_SW, S_RB, S_RB_W, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   fca_cmd_type        cmd_ff, cmd_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic [LW-1:0]      log_ff, log_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [LINK_W-1:0]  val_ff, val_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  res_ff, res_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic               at_head_ff, at_head_in;
   logic               st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [LINK_W-1:0]  rsp_value_ff, rsp_value_in;

   logic               t_we, t_re;
   logic [AW-1:0]      t_wa, t_ra;
   logic [LINK_W-1:0]  t_wd, t_rd;
   logic               l_we, l_re;
   logic [AW-1:0]      l_wa, l_ra;
   logic [LOG_W-1:0]   l_wd, l_rd;
   logic [LW-1:0]      lim;
   logic               val_no_link;
   logic               pop;

   fca_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_en(t_re), .rd_addr(t_ra), .rd_data(t_rd)
   );

   fca_ram #(.WIDTH(LOG_W), .DEPTH(TABLE_ENTRIES)) u_undo (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_en(l_re), .rd_addr(l_ra), .rd_data(l_rd)
   );

   assign lim = (32'(cfg.usable_entries) >= 32'(TABLE_ENTRIES)) ?
                LW'(TABLE_ENTRIES) : LW'(cfg.usable_entries);
   assign val_no_link = (val_ff == cfg.free_marker) || (val_ff == cfg.end_marker) ||
                        (32'(val_ff) >= 32'(TABLE_ENTRIES));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      log_in        = log_ff;
      cur_in        = cur_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      res_in        = res_ff;
      step_in       = step_ff;
      at_head_in    = at_head_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      pop  = 1'b0;
      t_we = 1'b0;
      t_wa = cur_ff;
      t_wd = cfg.free_marker;
      t_re = 1'b0;
      t_ra = cur_ff;
      l_we = 1'b0;
      l_wa = log_ff[AW-1:0];
      l_wd = {cur_ff, val_ff};
      l_re = 1'b0;
      l_ra = AW'(log_ff - 1'b1);
      case (state_ff)
         S_CLEAR: begin
            t_we   = 1'b1;
            t_wa   = cnt_ff[AW-1:0];
            t_wd   = RESET_FREE;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LW'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (front_stat.valid) begin
               pop        = 1'b1;
               cmd_in     = front_stat.cmd;
               val_in     = front_stat.cmd.chain_head;
               head_in    = front_stat.cmd.chain_head;
               at_head_in = 1'b1;
               step_in    = '0;
               cnt_in     = '0;
               log_in     = '0;
               res_in     = '0;
               st_in      = ST_OK;
               case (front_stat.cmd.op)
                  OP_LOAD: begin
                     t_we = (32'(front_stat.cmd.entry_index) < 32'(TABLE_ENTRIES));
                     t_wa = AW'(front_stat.cmd.entry_index);
                     t_wd = front_stat.cmd.entry_value;
                     state_in = S_OUT;
                  end
                  OP_RESIZE: state_in = S_RS_STEP;
                  OP_FREE:   state_in = S_FR;
                  OP_NTH:    state_in = S_NT;
                  OP_COUNT:  state_in = S_CN;
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_FR: begin
            if (val_no_link) begin
               state_in = S_OUT;
            end else begin
               t_re     = 1'b1;
               t_ra     = val_ff[AW-1:0];
               cur_in   = val_ff[AW-1:0];
               state_in = S_FR_W;
            end
         end
         S_FR_W: begin
            t_we     = 1'b1;
            val_in   = t_rd;
            state_in = S_FR;
         end
         S_NT: begin
            if ((step_ff < {1'b0, cmd_ff.entry_index}) &&
                (32'(val_ff) < 32'(TABLE_ENTRIES))) begin
               t_re     = 1'b1;
               t_ra     = val_ff[AW-1:0];
               state_in = S_NT_W;
            end else begin
               res_in   = val_ff;
               state_in = S_OUT;
            end
         end
         S_NT_W: begin
            val_in   = t_rd;
            step_in  = step_ff + 1'b1;
            state_in = S_NT;
         end
         S_CN: begin
            if (cnt_ff < lim) begin
               t_re     = 1'b1;
               t_ra     = cnt_ff[AW-1:0];
               state_in = S_CN_W;
            end else begin
               state_in = S_OUT;
            end
         end
         S_CN_W: begin
            if (t_rd == cfg.free_marker) begin
               res_in = res_ff + 1'b1;
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_CN;
         end
         S_RS_STEP: begin
            if (step_ff < cmd_ff.new_count) begin
               if (at_head_ff) begin
                  val_in   = head_ff;
                  state_in = S_RS_CHK;
               end else begin
                  t_re     = 1'b1;
                  state_in = S_RS_RD;
               end
            end else if (at_head_ff) begin
               val_in   = head_ff;
               head_in  = cfg.end_marker;
               state_in = S_RS_SUR;
            end else begin
               t_re     = 1'b1;
               state_in = S_RS_END;
            end
         end
         S_RS_RD: begin
            val_in   = t_rd;
            state_in = S_RS_CHK;
         end
         S_RS_CHK: begin
            if (!val_no_link) begin
               at_head_in = 1'b0;
               cur_in     = val_ff[AW-1:0];
               step_in    = step_ff + 1'b1;
               state_in   = S_RS_STEP;
            end else begin
               state_in = S_RS_SCAN;
            end
         end
         S_RS_SCAN: begin
            if (cnt_ff >= lim) begin
               state_in = S_RB;
            end else begin
               t_re     = 1'b1;
               t_ra     = cnt_ff[AW-1:0];
               state_in = S_RS_SCW;
            end
         end
         S_RS_SCW: begin
            cnt_in = cnt_ff + 1'b1;
            if (t_rd == cfg.free_marker) begin
               if (at_head_ff) begin
                  head_in = LINK_W'(cnt_ff);
               end else begin
                  t_we   = 1'b1;
                  t_wd   = LINK_W'(cnt_ff);
                  l_we   = 1'b1;
                  log_in = log_ff + 1'b1;
               end
               at_head_in = 1'b0;
               cur_in     = cnt_ff[AW-1:0];
               step_in    = step_ff + 1'b1;
               state_in   = S_RS_STEP;
            end else begin
               state_in = S_RS_SCAN;
            end
         end
         S_RS_END: begin
            val_in   = t_rd;
            t_we     = 1'b1;
            t_wd     = cfg.end_marker;
            state_in = S_RS_SUR;
         end
         S_RS_SUR: begin
            if ((step_ff < cmd_ff.old_count) && !val_no_link) begin
               t_re     = 1'b1;
               t_ra     = val_ff[AW-1:0];
               cur_in   = val_ff[AW-1:0];
               state_in = S_RS_SW;
            end else begin
               res_in   = head_ff;
               state_in = S_OUT;
            end
         end
         S_RS_SW: begin
            t_we     = 1'b1;
            val_in   = t_rd;
            step_in  = step_ff + 1'b1;
            state_in = S_RS_SUR;
         end
         S_RB: begin
            if (log_ff != '0) begin
               l_re     = 1'b1;
               log_in   = log_ff - 1'b1;
               state_in = S_RB_W;
            end else begin
               res_in   = cmd_ff.chain_head;
               st_in    = ST_NO_SPACE;
               state_in = S_OUT;
            end
         end
         S_RB_W: begin
            t_we     = 1'b1;
            t_wa     = l_rd[LOG_W-1:LINK_W];
            t_wd     = l_rd[LINK_W-1:0];
            state_in = S_RB;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_value_in  = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      log_ff        <= log_in;
      cur_ff        <= cur_in;
      val_ff        <= val_in;
      head_ff       <= head_in;
      res_ff        <= res_in;
      step_ff       <= step_in;
      at_head_ff    <= at_head_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign back_stat.pop       = pop;
   assign back_stat.init_done = (state_ff != S_CLEAR);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_value = rsp_value_ff;
endmodule

// ===== hdl/fca_checker.sv =====
// ---------------------------------------------------------------------------
// fca_checker
// port-level checks of the chain allocator
// ---------------------------------------------------------------------------
module fca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [15:0] rsp_result_value,
   input logic        csr_ready
);
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_value))
      else $error("stalled result beat changed");

   a_csr_open: assert property (@(posedge clock)
      !reset |-> csr_ready)
      else $error("register port not ready");
endmodule

bind fat_chain_allocator_core fca_checker u_fca_checker (
   .clock(clock), .reset(reset), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status), .rsp_result_value(rsp_ch.result_value),
   .csr_ready(csr_ch.ready)
);

// ===== verif/fca_chain_checker.sv =====
// ---------------------------------------------------------------------------
// fca_chain_checker
// watches the register, request and result channels of the chain allocator,
// keeps its own copy of the link table and settings, works out the result of
// every accepted request and compares each result beat with the oldest one
// ---------------------------------------------------------------------------
module fca_chain_checker
   import fca_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   fca_req_if    req_ch,
   fca_rsp_if    rsp_ch,
   fca_csr_if    csr_ch,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH = 1024;

   typedef struct {
      logic              status;
      logic [LINK_W-1:0] value;
   } alloc_result_type;

   logic [LINK_W-1:0]  link_tab [DEPTH];
   logic [LINK_W-1:0]  work_tab [DEPTH];
   logic [COUNT_W-1:0] usable;
   logic [LINK_W-1:0]  free_mark;
   logic [LINK_W-1:0]  end_mark;
   alloc_result_type   awaited [$];

   function automatic int unsigned scan_bound();
      return (usable < DEPTH) ? usable : DEPTH;
   endfunction

   function automatic bit is_stop(int unsigned v);
      return v == free_mark || v == end_mark || v >= DEPTH;
   endfunction

   function automatic alloc_result_type resize_chain(int unsigned head, int unsigned newc,
                                                     int unsigned oldc);
      alloc_result_type r;
      int unsigned      headv, cur, scan, lim, s, n, nn, t;
      bit               at_head;
      headv   = head;
      at_head = 1;
      cur     = 0;
      scan    = 0;
      lim     = scan_bound();
      r.status = ST_NO_SPACE;
      r.value  = head[LINK_W-1:0];
      work_tab = link_tab;
      for (s = 0; s < newc; s++) begin
         n = at_head ? headv : work_tab[cur];
         if (is_stop(n)) begin
            while (scan < lim && work_tab[scan] != free_mark) scan++;
            if (scan >= lim) return r;
            n = scan;
            if (at_head) headv = n;
            else work_tab[cur] = n[LINK_W-1:0];
            scan = n + 1;
         end
         at_head = 0;
         cur = n;
      end
      nn = at_head ? headv : work_tab[cur];
      if (at_head) headv = end_mark;
      else work_tab[cur] = end_mark;
      for (; s < oldc; s++) begin
         if (is_stop(nn)) break;
         t = work_tab[nn];
         work_tab[nn] = free_mark;
         nn = t;
      end
      link_tab = work_tab;
      r.status = ST_OK;
      r.value  = headv[LINK_W-1:0];
      return r;
   endfunction

   function automatic alloc_result_type serve_request(logic [TYPE_W-1:0] kind,
                                                      int unsigned head, int unsigned newc,
                                                      int unsigned oldc, int unsigned idx,
                                                      logic [LINK_W-1:0] val);
      alloc_result_type r;
      int unsigned      c, i, t;
      r.status = ST_OK;
      r.value  = '0;
      case (kind)
         REQ_LOAD: begin
            if (idx < DEPTH) link_tab[idx] = val;
         end
         REQ_RESIZE: r = resize_chain(head, newc, oldc);
         REQ_FREE: begin
            c = head;
            while (!is_stop(c)) begin
               t = link_tab[c];
               link_tab[c] = free_mark;
               c = t;
            end
         end
         REQ_NTH: begin
            c = head;
            for (i = 0; i < idx && c < DEPTH; i++) c = link_tab[c];
            r.value = c[LINK_W-1:0];
         end
         REQ_COUNT: begin
            c = 0;
            for (i = 0; i < scan_bound(); i++) if (link_tab[i] == free_mark) c++;
            r.value = c[LINK_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         usable    = RESET_USABLE;
         free_mark = RESET_FREE;
         end_mark  = RESET_END;
         foreach (link_tab[i]) link_tab[i] = RESET_FREE;
         awaited.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.wr_index)
               CSR_USABLE: usable    = csr_ch.wr_data[COUNT_W-1:0];
               CSR_FREE:   free_mark = csr_ch.wr_data;
               CSR_END:    end_mark  = csr_ch.wr_data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            awaited.push_back(serve_request(req_ch.req_type, req_ch.chain_head,
                                            req_ch.new_count, req_ch.old_count,
                                            req_ch.entry_index, req_ch.entry_value));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.value  = rsp_ch.result_value;
            if (awaited.size() == 0) begin
               $error("result beat with nothing awaited: status %0d value %0d",
                      got.status, got.value);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count <= fail_count + 1;
               end else if (got.value !== want.value) begin
                  $error("result_value: expected %0d, got %0d", want.value, got.value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= awaited.size();
      end
   end

endmodule

// ===== verif/fat_chain_allocator_core_tb.sv =====
// ---------------------------------------------------------------------------
// fat_chain_allocator_core_tb
// drives directed and random requests into the chain allocator under several
// register settings, with random gaps and stalls on both channels; the
// checker beside the block predicts and compares every result beat
// ---------------------------------------------------------------------------
module fat_chain_allocator_core_tb;
   import fca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   unsigned heads [$];
   bit   src_quiet, snk_quiet;
   logic [LINK_W-1:0]  cur_free, cur_end;

   fca_req_if req_if ();
   fca_rsp_if rsp_if ();
   fca_csr_if csr_if ();

   fat_chain_allocator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   fca_chain_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_ch     (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #1s;
      $display("fat_chain_allocator_core_tb: errors");
      $finish;
   end

   // sector numbers handed back by the block, reused as chain heads
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready && rsp_if.result_value < 1024) begin
         heads.push_back(rsp_if.result_value);
         if (heads.size() > 24) void'(heads.pop_front());
      end
   end

   initial begin
      int unsigned stall, n;
      rsp_if.ready <= 1'b0;
      n = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (n % 32 == 0) snk_quiet = ($urandom_range(0, 3) == 0);
         n++;
         stall = snk_quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12));
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   task automatic send_req(logic [TYPE_W-1:0] kind, logic [LINK_W-1:0] head,
                           logic [COUNT_W-1:0] newc, logic [COUNT_W-1:0] oldc,
                           logic [INDEX_W-1:0] idx, logic [LINK_W-1:0] val);
      int unsigned gap;
      gap = src_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.chain_head  <= head;
      req_if.new_count   <= newc;
      req_if.old_count   <= oldc;
      req_if.entry_index <= idx;
      req_if.entry_value <= val;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, logic [LINK_W-1:0] data);
      csr_if.valid    <= 1'b1;
      csr_if.wr_index <= idx;
      csr_if.wr_data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [COUNT_W-1:0] u, logic [LINK_W-1:0] f,
                                 logic [LINK_W-1:0] e);
      drain();
      write_reg(CSR_USABLE, 16'(u));
      write_reg(CSR_FREE, f);
      write_reg(CSR_END, e);
      cur_free   = f;
      cur_end    = e;
   endtask

   function automatic logic [LINK_W-1:0] pick_head();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0 || heads.size() == 0) return (r < 5) ? cur_end : cur_free;
      if (r == 1) return LINK_W'($urandom_range(0, 1023));
      return LINK_W'(heads[$urandom_range(0, heads.size() - 1)]);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      if ($urandom_range(0, 49) == 0) return COUNT_W'($urandom_range(0, 2047));
      return COUNT_W'($urandom_range(0, 12));
   endfunction

   task automatic random_item();
      int unsigned r, v;
      logic [LINK_W-1:0] val;
      r = $urandom_range(0, 99);
      v = $urandom_range(0, 3);
      val = (v == 0) ? cur_free : (v == 1) ? cur_end :
            (v == 2) ? LINK_W'($urandom_range(0, 1023)) : LINK_W'($urandom);
      if (r < 35)
         send_req(REQ_RESIZE, pick_head(), pick_count(), pick_count(),
                  INDEX_W'($urandom), LINK_W'($urandom));
      else if (r < 50)
         send_req(REQ_FREE, pick_head(), COUNT_W'($urandom), COUNT_W'($urandom),
                  INDEX_W'($urandom), LINK_W'($urandom));
      else if (r < 63)
         send_req(REQ_NTH, pick_head(), COUNT_W'($urandom), COUNT_W'($urandom),
                  ($urandom_range(0, 19) == 0) ? INDEX_W'($urandom) :
                  INDEX_W'($urandom_range(0, 15)), LINK_W'($urandom));
      else if (r < 70)
         send_req(REQ_COUNT, LINK_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom),
                  INDEX_W'($urandom), LINK_W'($urandom));
      else if (r < 88)
         send_req(REQ_LOAD, LINK_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom),
                  INDEX_W'($urandom), val);
      else if (r < 95)
         send_req(REQ_RESIZE, LINK_W'($urandom), pick_count(), pick_count(),
                  INDEX_W'($urandom), LINK_W'($urandom));
      else
         send_req(TYPE_W'($urandom_range(REQ_COUNT + 1, 7)), LINK_W'($urandom),
                  COUNT_W'($urandom), COUNT_W'($urandom), INDEX_W'($urandom),
                  LINK_W'($urandom));
   endtask

   task automatic random_phase(int unsigned items);
      for (int unsigned i = 0; i < items; i++) begin
         if (i % 40 == 0) src_quiet = ($urandom_range(0, 3) == 0);
         if (i == items / 2 && $urandom_range(0, 1) == 0) drain();
         random_item();
      end
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_LOAD;
      req_if.chain_head  <= '0;
      req_if.new_count   <= '0;
      req_if.old_count   <= '0;
      req_if.entry_index <= '0;
      req_if.entry_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.wr_index    <= CSR_USABLE;
      csr_if.wr_data     <= '0;
      src_quiet = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      apply_settings(RESET_USABLE, RESET_FREE, RESET_END);

      send_req(REQ_COUNT, 0, 0, 0, 0, 0);
      send_req(REQ_RESIZE, RESET_FREE, 3, 0, 0, 0);
      send_req(REQ_RESIZE, 0, 6, 3, 0, 0);
      send_req(REQ_RESIZE, 0, 1, 6, 0, 0);
      send_req(REQ_RESIZE, 0, 0, 1, 0, 0);
      send_req(REQ_RESIZE, RESET_END, 0, 0, 0, 0);
      send_req(REQ_LOAD, 0, 0, 0, 0, 16'd1);
      send_req(REQ_LOAD, 0, 0, 0, 1, 16'd2000);
      send_req(REQ_RESIZE, 0, 4, 4, 0, 0);
      send_req(REQ_NTH, 0, 0, 0, 3, 0);
      send_req(REQ_NTH, 16'd2000, 0, 0, 5, 0);
      send_req(REQ_NTH, 16'hFFFF, 0, 0, 10'h3FF, 0);
      send_req(REQ_LOAD, 0, 0, 0, 10'h3FF, 16'hFFFF);
      send_req(REQ_LOAD, 0, 0, 0, 10'h3FF, 16'h0000);
      send_req(REQ_FREE, 0, 0, 0, 0, 0);
      send_req(REQ_FREE, RESET_END, 0, 0, 0, 0);
      send_req(REQ_RESIZE, 16'd5, 11'd1025, 0, 0, 0);
      send_req(REQ_RESIZE, 16'hFFFF, 11'd2047, 11'd2047, 0, 0);
      send_req(REQ_COUNT, 0, 0, 0, 0, 0);
      for (int k = REQ_COUNT + 1; k <= 7; k++) send_req(TYPE_W'(k), 16'hFFFF, 11'h7FF,
                                                       11'h7FF, 10'h3FF, 16'hFFFF);
      random_phase(100);

      apply_settings(11'd16, RESET_FREE, RESET_END);
      random_phase(90);
      apply_settings(11'd2047, 16'h0000, 16'hFFFF);
      random_phase(90);
      apply_settings(11'd0, RESET_FREE, RESET_END);
      random_phase(60);
      apply_settings(11'd1, 16'h1234, 16'h0000);
      random_phase(70);
      apply_settings(11'd300, RESET_FREE, RESET_END);
      random_phase(150);

      drain();
      if (fail_count == 0 && pending == 0)
         $display("fat_chain_allocator_core_tb: clean");
      else
         $display("fat_chain_allocator_core_tb: errors");
      $finish;
   end

endmodule
